@@ rtl/cfc_pkg.sv @@
// Shared constants, codes and control types for the circular FIFO with cursor.
package cfc_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = IDX_W + 1;
  localparam int DATA_W = 32;
  localparam int POS_W  = 5;
  localparam int CUR_W  = POS_W + 1;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_START  = 2'd2,
    CMD_NEXT   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  // controller -> datapath strobes
  typedef struct packed {
    logic load;  // capture the input transfer
    logic exec;  // run the captured command
  } dp_ctl_t;

endpackage

@@ rtl/cfc_ctrl.sv @@
// Handshake sequencer for the circular FIFO with cursor.
module cfc_ctrl import cfc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_ctl_t dp_ctl
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_HOLD,
    S_HOLD_PEND
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, in_ready_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_xfer, out_xfer;

  assign in_xfer  = in_valid & in_ready_r;
  assign out_xfer = out_valid_r & out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_HOLD;
      end
      S_HOLD: begin
        if (out_xfer && in_xfer) state_nxt = S_EXEC;
        else if (out_xfer)       state_nxt = S_IDLE;
        else if (in_xfer)        state_nxt = S_HOLD_PEND;
      end
      S_HOLD_PEND: begin
        if (out_xfer) state_nxt = S_EXEC;
      end
      default: state_nxt = S_IDLE;
    endcase
    in_ready_nxt  = (state_nxt == S_IDLE) || (state_nxt == S_HOLD);
    out_valid_nxt = (state_nxt == S_HOLD) || (state_nxt == S_HOLD_PEND);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_ready_r  <= in_ready_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready    = in_ready_r;
  assign out_valid   = out_valid_r;
  assign dp_ctl.load = in_xfer;
  assign dp_ctl.exec = (state_r == S_EXEC);

  a_ready_valid_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready_r && out_valid_r && state_r == S_HOLD_PEND))
    else $error("input taken while a transfer is already pending");

  a_exec_then_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) |=> (out_valid_r && state_r == S_HOLD))
    else $error("result not presented after execution");

  a_no_load_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC || state_r == S_HOLD_PEND) |-> !in_ready_r)
    else $error("input open while captured item still unused");

endmodule

@@ rtl/cfc_dp.sv @@
// Datapath: ring storage, pointers, cursor and result registers.
module cfc_dp import cfc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  dp_ctl_t                  dp_ctl,
  input  logic [1:0]               in_command,
  input  logic [DATA_W-1:0]        in_push_data,
  input  logic signed [POS_W-1:0]  in_start_pos,
  output logic [DATA_W-1:0]        out_read_data,
  output logic [1:0]               out_status,
  output logic [CNT_W-1:0]         out_count
);

  logic [DATA_W-1:0] mem [DEPTH];

  // captured transfer
  cmd_t                    cmd_r;
  logic [DATA_W-1:0]       data_r;
  logic signed [POS_W-1:0] sp_r;

  logic [IDX_W-1:0]        head_r, head_nxt;
  logic [IDX_W-1:0]        tail_r, tail_nxt;
  logic [CNT_W-1:0]        fill_r, fill_nxt;
  logic signed [CUR_W-1:0] cursor_r, cursor_nxt;

  logic [DATA_W-1:0]       rdata_r;
  status_t                 status_r, status_nxt;
  logic [CNT_W-1:0]        count_r;

  logic signed [CUR_W:0]   pos;
  logic                    pos_ok;
  logic [IDX_W-1:0]        rd_addr;
  logic                    rd_en, wr_en;
  logic                    full, empty;

  assign full  = (fill_r == CNT_W'(DEPTH));
  assign empty = (fill_r == '0);

  // logical position; a negative cursor counts back from the tail
  assign pos = {cursor_r[CUR_W-1], cursor_r}
             + (cursor_r[CUR_W-1] ? $signed({2'b00, fill_r}) : '0);
  assign pos_ok = !pos[CUR_W] && (pos[CUR_W-1:0] < {1'b0, fill_r});

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    fill_nxt   = fill_r;
    cursor_nxt = cursor_r;
    status_nxt = ST_OK;
    rd_addr    = head_r;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    case (cmd_r)
      CMD_INSERT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          wr_en    = 1'b1;
          tail_nxt = tail_r + 1'b1;
          fill_nxt = fill_r + 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (empty) begin
          status_nxt = ST_INVALID;
        end else begin
          rd_en    = 1'b1;
          head_nxt = head_r + 1'b1;
          fill_nxt = fill_r - 1'b1;
        end
      end
      CMD_START: begin
        cursor_nxt = {sp_r[POS_W-1], sp_r};
      end
      CMD_NEXT: begin
        if (!pos_ok) begin
          status_nxt = ST_INVALID;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = head_r + pos[IDX_W-1:0];
          cursor_nxt = cursor_r[CUR_W-1] ? cursor_r - 6'sd1 : cursor_r + 6'sd1;
        end
      end
      default: status_nxt = ST_OK;
    endcase
  end

  // capture registers, storage and result registers, no reset needed
  always_ff @(posedge clk) begin
    if (dp_ctl.load) begin
      cmd_r  <= cmd_t'(in_command);
      data_r <= in_push_data;
      sp_r   <= in_start_pos;
    end
    if (dp_ctl.exec && wr_en) mem[tail_r] <= data_r;
    if (dp_ctl.exec) begin
      rdata_r  <= rd_en ? mem[rd_addr] : '0;
      status_r <= status_nxt;
      count_r  <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      tail_r   <= '0;
      fill_r   <= '0;
      cursor_r <= '0;
    end else if (dp_ctl.exec) begin
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      fill_r   <= fill_nxt;
      cursor_r <= cursor_nxt;
    end
  end

  assign out_read_data = rdata_r;
  assign out_status    = status_r;
  assign out_count     = count_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(DEPTH))
    else $error("fill count beyond depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (IDX_W'(tail_r - head_r) == fill_r[IDX_W-1:0]))
    else $error("pointer gap disagrees with fill count");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (dp_ctl.exec && cmd_r == CMD_INSERT && !full) |=> (fill_r == $past(fill_r) + 1'b1))
    else $error("insert did not grow the queue");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cursor_r >= -6'sd17) && (cursor_r <= 6'sd16))
    else $error("cursor out of reachable range");

endmodule

@@ rtl/circular_fifo_with_cursor_unit.sv @@
// Top level of the circular FIFO with traversal cursor.
// A 16-entry ring of 32-bit elements with insert (tail), remove (head),
// start traversal (load a signed cursor, negative counts back from the tail,
// so -1 is the newest element) and traversal next (read the element at the
// cursor, then step the cursor away from its origin). Every transfer in gives
// exactly one result: read_data (popped or traversed element, else zero),
// status (0 ok, 1 empty queue or invalid position, 2 insert dropped as the
// queue is full) and the element count after the step. Failed operations
// leave all state untouched; insert and remove do not move the cursor.
// Sequencing: an item is captured at its transfer and executed in the
// execute state (pointer update plus one access to the storage array); the
// result is presented the cycle after. A new item may be taken while a
// result waits, but execution waits for the result register to drain.
// The input is closed during the execute cycle, so no new item is taken
// while one executes, even when results are taken at once.
module circular_fifo_with_cursor_unit import cfc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_command,
  input  logic [DATA_W-1:0]        in_push_data,
  input  logic signed [POS_W-1:0]  in_start_pos,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [DATA_W-1:0]        out_read_data,
  output logic [1:0]               out_status,
  output logic [CNT_W-1:0]         out_count
);

  dp_ctl_t dp_ctl;

  // handshake sequencing: capture, execute, present
  cfc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dp_ctl    (dp_ctl)
  );

  // storage, pointers, cursor and result registers
  cfc_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .dp_ctl        (dp_ctl),
    .in_command    (in_command),
    .in_push_data  (in_push_data),
    .in_start_pos  (in_start_pos),
    .out_read_data (out_read_data),
    .out_status    (out_status),
    .out_count     (out_count)
  );

endmodule
